@@ rtl/hcbm_pkg.sv @@
// types, constants, symbol tables and control program for the hill cipher block multiplier
package hcbm_pkg;

    // field and register widths
    localparam int CHAR_W   = 8;
    localparam int SYM_W    = 9;
    localparam int KEY_W    = 5;
    localparam int KEY_DIM  = 4;
    localparam int ROW_W    = KEY_W * KEY_DIM;
    localparam int ALPHA_W  = 5;
    localparam int BSIZE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = ROW_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd5;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 5'd26;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 3'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_A     = 8'd65;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'd33;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'd45;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;

    // symbol values
    localparam logic signed [SYM_W-1:0] SYM_SPACE = 9'sd26;
    localparam logic signed [SYM_W-1:0] SYM_BANG  = 9'sd27;
    localparam logic signed [SYM_W-1:0] SYM_COMMA = 9'sd28;
    localparam logic signed [SYM_W-1:0] SYM_DASH  = 9'sd29;
    localparam logic signed [SYM_W-1:0] SYM_DOT   = 9'sd30;
    localparam logic signed [SYM_W-1:0] SYM_BIAS  = 9'sd65;
    localparam logic [ALPHA_W-1:0] VAL_LETTERS = 5'd26;
    localparam logic [ALPHA_W-1:0] VAL_SPACE   = 5'd26;
    localparam logic [ALPHA_W-1:0] VAL_BANG    = 5'd27;
    localparam logic [ALPHA_W-1:0] VAL_COMMA   = 5'd28;
    localparam logic [ALPHA_W-1:0] VAL_DASH    = 5'd29;
    localparam logic [ALPHA_W-1:0] VAL_DOT     = 5'd30;

    // sequencer
    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT      = 4'd0;
    localparam step_t ST_CHECK     = 4'd1;
    localparam step_t ST_CHECK_EOM = 4'd2;
    localparam step_t ST_PAD       = 4'd3;
    localparam step_t ST_BLK_INIT  = 4'd4;
    localparam step_t ST_ROW_INIT  = 4'd5;
    localparam step_t ST_MAC       = 4'd6;
    localparam step_t ST_REM_INIT  = 4'd7;
    localparam step_t ST_REM_STEP  = 4'd8;
    localparam step_t ST_EMIT      = 4'd9;
    localparam step_t ST_ROW_END   = 4'd10;
    localparam step_t ST_DONE      = 4'd11;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_IN,
        COND_FULL,
        COND_NOT_EOM,
        COND_PAD_MORE,
        COND_COL_MORE,
        COND_K_MORE,
        COND_OUT_BUSY,
        COND_ROW_MORE
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  pad;
        logic  blk_init;
        logic  row_init;
        logic  mac;
        logic  rem_init;
        logic  rem_step;
        logic  emit;
        logic  clr_fill;
        cond_t cond;
        step_t target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        in_ready: 1'b0, pad: 1'b0, blk_init: 1'b0, row_init: 1'b0, mac: 1'b0,
        rem_init: 1'b0, rem_step: 1'b0, emit: 1'b0, clr_fill: 1'b0,
        cond: COND_NONE, target: ST_WAIT
    };

    // control program: jump to target when cond holds, else fall through
    function automatic ucode_t ucode(input step_t step);
        ucode_t uc;
        uc = UC_NOP;
        case (step)
            ST_WAIT:
            begin
                uc.in_ready = 1'b1;
                uc.cond     = COND_NO_IN;
                uc.target   = ST_WAIT;
            end
            ST_CHECK:
            begin
                uc.cond   = COND_FULL;
                uc.target = ST_BLK_INIT;
            end
            ST_CHECK_EOM:
            begin
                uc.cond   = COND_NOT_EOM;
                uc.target = ST_WAIT;
            end
            ST_PAD:
            begin
                uc.pad    = 1'b1;
                uc.cond   = COND_PAD_MORE;
                uc.target = ST_PAD;
            end
            ST_BLK_INIT:
            begin
                uc.blk_init = 1'b1;
            end
            ST_ROW_INIT:
            begin
                uc.row_init = 1'b1;
            end
            ST_MAC:
            begin
                uc.mac    = 1'b1;
                uc.cond   = COND_COL_MORE;
                uc.target = ST_MAC;
            end
            ST_REM_INIT:
            begin
                uc.rem_init = 1'b1;
            end
            ST_REM_STEP:
            begin
                uc.rem_step = 1'b1;
                uc.cond     = COND_K_MORE;
                uc.target   = ST_REM_STEP;
            end
            ST_EMIT:
            begin
                uc.emit   = 1'b1;
                uc.cond   = COND_OUT_BUSY;
                uc.target = ST_EMIT;
            end
            ST_ROW_END:
            begin
                uc.cond   = COND_ROW_MORE;
                uc.target = ST_ROW_INIT;
            end
            ST_DONE:
            begin
                uc.clr_fill = 1'b1;
                uc.cond     = COND_ALWAYS;
                uc.target   = ST_WAIT;
            end
            default:
            begin
                uc.cond   = COND_ALWAYS;
                uc.target = ST_WAIT;
            end
        endcase
        return uc;
    endfunction

    // byte to symbol
    function automatic logic signed [SYM_W-1:0] sym_of_byte(input logic [CHAR_W-1:0] c);
        logic signed [SYM_W-1:0] s;
        case (c)
            CH_SPACE: s = SYM_SPACE;
            CH_BANG:  s = SYM_BANG;
            CH_COMMA: s = SYM_COMMA;
            CH_DASH:  s = SYM_DASH;
            CH_DOT:   s = SYM_DOT;
            default:  s = $signed({1'b0, c}) - SYM_BIAS;
        endcase
        return s;
    endfunction

    // reduced value to byte
    function automatic logic [CHAR_W-1:0] byte_of_value(input logic [ALPHA_W-1:0] v);
        logic [CHAR_W-1:0] b;
        if (v < VAL_LETTERS)
        begin
            b = CH_A + {3'b000, v};
        end
        else
        begin
            case (v)
                VAL_SPACE: b = CH_SPACE;
                VAL_BANG:  b = CH_BANG;
                VAL_COMMA: b = CH_COMMA;
                VAL_DASH:  b = CH_DASH;
                VAL_DOT:   b = CH_DOT;
                default:   b = CH_A;
            endcase
        end
        return b;
    endfunction

endpackage

@@ rtl/hill_cipher_block_multiply.sv @@
// hill cipher block multiplier: microcoded sequencer over one multiply-accumulate datapath
// a block's characters follow its last input transaction (padded first with spaces if the
// message ends short), one character per row; the shared mac unit (one product per column) and
// the bit-serial modulo (MAG_W quotient bits; MAG_W = 15 at MAX_N = 4) set the rate, and a busy
// output stalls the emit step; reset clears the sequencer, fill count, end-of-message flag,
// symbol buffer, counters, output valid and configuration registers to their defaults
module hill_cipher_block_multiply #(
    parameter int MAX_N = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [hcbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input characters
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hcbm_pkg::CHAR_W-1:0]         char_in,
    input  logic                                end_of_message,
    // output characters
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hcbm_pkg::CHAR_W-1:0]         char_out,
    output logic                                last_of_block
);

    // symbol buffer index, counters that can hold n itself
    localparam int IDX_W = $clog2(MAX_N);
    localparam int CNT_W = $clog2(MAX_N + 1);
    // accumulator: worst case sum is 31 * 190 * MAX_N, lowest is -31 * 65 * MAX_N
    localparam int ACC_W = $clog2(31 * 190 * MAX_N + 1) + 1;
    localparam int MAG_W = ACC_W - 1;
    localparam int DIV_W = MAG_W + hcbm_pkg::ALPHA_W - 1;
    localparam int K_W   = $clog2(MAG_W);
    localparam int PROD_W = hcbm_pkg::KEY_W + 1 + hcbm_pkg::SYM_W;

    // configuration registers
    logic [hcbm_pkg::ROW_W-1:0]   key_rows_reg [hcbm_pkg::KEY_DIM];
    logic [hcbm_pkg::ALPHA_W-1:0] alpha_reg;
    logic [hcbm_pkg::BSIZE_W-1:0] bsize_reg;

    // sequencer
    hcbm_pkg::step_t  step_reg, step_next;
    hcbm_pkg::ucode_t uc;
    logic             jump;

    // datapath state
    logic signed [hcbm_pkg::SYM_W-1:0] sym_buf_reg [MAX_N];
    logic [CNT_W-1:0]        fill_reg;
    logic                    eom_reg;
    logic [CNT_W-1:0]        row_reg;
    logic [CNT_W-1:0]        col_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [MAG_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [K_W-1:0]          k_reg;
    logic                    neg_reg;

    // output holding register
    logic                         out_valid_reg;
    logic [hcbm_pkg::CHAR_W-1:0]  char_out_reg;
    logic                         last_reg;

    // derived values
    logic [CNT_W-1:0]              n_val;
    logic                          in_fire;
    logic                          out_busy;
    logic [hcbm_pkg::KEY_W-1:0]    key_e;
    logic signed [PROD_W-1:0]      prod;
    logic signed [ACC_W-1:0]       acc_neg;
    logic [hcbm_pkg::ALPHA_W-1:0]  rem5;
    logic [hcbm_pkg::ALPHA_W-1:0]  red_val;
    logic [CNT_W:0]                fill_inc, col_inc, row_inc, n_ext;

    // active block size: zero acts as one, large values saturate
    always_comb
    begin
        if (bsize_reg == '0)
        begin
            n_val = CNT_W'(1);
        end
        else if (int'(bsize_reg) > MAX_N)
        begin
            n_val = CNT_W'(MAX_N);
        end
        else
        begin
            n_val = CNT_W'(bsize_reg);
        end
    end

    assign n_ext    = {1'b0, n_val};
    assign fill_inc = {1'b0, fill_reg} + 1'b1;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;

    assign uc       = hcbm_pkg::ucode(step_reg);
    assign in_ready = uc.in_ready;
    assign in_fire  = in_valid && uc.in_ready;
    assign out_busy = out_valid_reg && !out_ready;

    // key entries beyond the four stored rows and columns read as zero
    always_comb
    begin
        if (int'(row_reg) < hcbm_pkg::KEY_DIM && int'(col_reg) < hcbm_pkg::KEY_DIM)
        begin
            key_e = key_rows_reg[row_reg[1:0]][col_reg[1:0] * hcbm_pkg::KEY_W +: hcbm_pkg::KEY_W];
        end
        else
        begin
            key_e = '0;
        end
    end

    assign prod    = $signed({1'b0, key_e}) * sym_buf_reg[col_reg[IDX_W-1:0]];
    assign acc_neg = -acc_reg;

    // floor modulo fix-up after the magnitude remainder
    assign rem5 = rem_reg[hcbm_pkg::ALPHA_W-1:0];
    always_comb
    begin
        if (alpha_reg == '0)
        begin
            red_val = '0;
        end
        else if (neg_reg && rem5 != '0)
        begin
            red_val = alpha_reg - rem5;
        end
        else
        begin
            red_val = rem5;
        end
    end

    // jump condition and next step
    always_comb
    begin
        case (uc.cond)
            hcbm_pkg::COND_NONE:     jump = 1'b0;
            hcbm_pkg::COND_ALWAYS:   jump = 1'b1;
            hcbm_pkg::COND_NO_IN:    jump = !in_valid;
            hcbm_pkg::COND_FULL:     jump = ({1'b0, fill_reg} >= n_ext);
            hcbm_pkg::COND_NOT_EOM:  jump = !eom_reg;
            hcbm_pkg::COND_PAD_MORE: jump = (fill_inc < n_ext);
            hcbm_pkg::COND_COL_MORE: jump = (col_inc < n_ext);
            hcbm_pkg::COND_K_MORE:   jump = (k_reg != '0);
            hcbm_pkg::COND_OUT_BUSY: jump = out_busy;
            hcbm_pkg::COND_ROW_MORE: jump = ({1'b0, row_reg} < n_ext);
            default:                 jump = 1'b0;
        endcase
        step_next = jump ? uc.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= hcbm_pkg::ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // configuration registers; a block size write drops any partial block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hcbm_pkg::KEY_DIM; i++)
            begin
                key_rows_reg[i] <= '0;
            end
            alpha_reg <= hcbm_pkg::ALPHA_RESET;
            bsize_reg <= hcbm_pkg::BSIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcbm_pkg::CFG_KEY_ROW_ZERO:  key_rows_reg[0] <= cfg_data;
                hcbm_pkg::CFG_KEY_ROW_ONE:   key_rows_reg[1] <= cfg_data;
                hcbm_pkg::CFG_KEY_ROW_TWO:   key_rows_reg[2] <= cfg_data;
                hcbm_pkg::CFG_KEY_ROW_THREE: key_rows_reg[3] <= cfg_data;
                hcbm_pkg::CFG_ALPHABET_SIZE: alpha_reg <= cfg_data[hcbm_pkg::ALPHA_W-1:0];
                hcbm_pkg::CFG_BLOCK_SIZE:    bsize_reg <= cfg_data[hcbm_pkg::BSIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // symbol gathering and padding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_N; i++)
            begin
                sym_buf_reg[i] <= '0;
            end
            fill_reg <= '0;
            eom_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                sym_buf_reg[fill_reg[IDX_W-1:0]] <= hcbm_pkg::sym_of_byte(char_in);
                fill_reg <= fill_inc[CNT_W-1:0];
                eom_reg  <= end_of_message;
            end
            else if (uc.pad)
            begin
                sym_buf_reg[fill_reg[IDX_W-1:0]] <= hcbm_pkg::SYM_SPACE;
                fill_reg <= fill_inc[CNT_W-1:0];
            end
            else if (uc.clr_fill)
            begin
                fill_reg <= '0;
            end
            if (cfg_we && cfg_index == hcbm_pkg::CFG_BLOCK_SIZE)
            begin
                fill_reg <= '0;
            end
        end
    end

    // row/column counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            if (uc.blk_init)
            begin
                row_reg <= '0;
            end
            else if (uc.emit && !out_busy)
            begin
                row_reg <= row_inc[CNT_W-1:0];
            end
            if (uc.row_init)
            begin
                col_reg <= '0;
            end
            else if (uc.mac)
            begin
                col_reg <= col_inc[CNT_W-1:0];
            end
        end
    end

    // multiply-accumulate and restoring remainder, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (uc.row_init)
        begin
            acc_reg <= '0;
        end
        else if (uc.mac)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (uc.rem_init)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            rem_reg <= acc_reg[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];
            div_reg <= DIV_W'(alpha_reg) << (MAG_W - 1);
            k_reg   <= K_W'(MAG_W - 1);
        end
        else if (uc.rem_step)
        begin
            if ({{(DIV_W - MAG_W){1'b0}}, rem_reg} >= div_reg)
            begin
                rem_reg <= rem_reg - div_reg[MAG_W-1:0];
            end
            div_reg <= div_reg >> 1;
            k_reg   <= k_reg - 1'b1;
        end
    end

    // output register: holds one character until the downstream transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uc.emit && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.emit && !out_busy)
        begin
            char_out_reg <= hcbm_pkg::byte_of_value(red_val);
            last_reg     <= (row_inc == n_ext);
        end
    end

    assign out_valid     = out_valid_reg;
    assign char_out      = char_out_reg;
    assign last_of_block = last_reg;

endmodule
